// ===== rtl/rlq_pkg.sv =====
// Package for the retransmission level queues: sizes, operation and status codes,
// and the entry, control and status types shared by the cell, queue and top level.
// No dependencies.
package rlq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int HANDLE_BITS = 16;
    localparam int SIZE_BITS   = 16;
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int NUM_Q       = 5;
    localparam int QSEL_BITS   = 3;

    localparam logic [7:0] CRYPTO_TYPE = 8'h06;

    localparam logic [QSEL_BITS-1:0] Q_INIT_PLAIN  = 3'd0;
    localparam logic [QSEL_BITS-1:0] Q_INIT_CRYPTO = 3'd1;
    localparam logic [QSEL_BITS-1:0] Q_HS_PLAIN    = 3'd2;
    localparam logic [QSEL_BITS-1:0] Q_HS_CRYPTO   = 3'd3;
    localparam logic [QSEL_BITS-1:0] Q_APP         = 3'd4;

    typedef enum logic [2:0] {
        FUNC_ADD_INIT = 3'd0,
        FUNC_ADD_HS   = 3'd1,
        FUNC_ADD_APP  = 3'd2,
        FUNC_GET_INIT = 3'd3,
        FUNC_GET_HS   = 3'd4,
        FUNC_GET_APP  = 3'd5,
        FUNC_DROP     = 3'd6,
        FUNC_NOP      = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_LEVEL = 2'd2
    } status_t;

    localparam logic [1:0] LVL_INIT = 2'd0;
    localparam logic [1:0] LVL_HS   = 2'd1;

    typedef struct packed {
        logic [HANDLE_BITS-1:0] handle;
        logic [SIZE_BITS-1:0]   size;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic flush;
    } q_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic pending_next;
    } q_stat_t;

endpackage

// ===== rtl/rlq_cell.sv =====
// One storage cell of a queue row: holds a single entry, loads a new entry
// or takes its upper neighbour's entry when the row shifts. Uses rlq_pkg.
module rlq_cell (
    input  logic            aclk,
    input  logic            load_en,
    input  logic            shift_en,
    input  rlq_pkg::entry_t load_data,
    input  rlq_pkg::entry_t shift_data,
    output rlq_pkg::entry_t data_q
);

    rlq_pkg::entry_t data_reg;
    rlq_pkg::entry_t data_next;

    always_comb begin
        data_next = data_reg;
        if (load_en) begin
            data_next = load_data;
        end else if (shift_en) begin
            data_next = shift_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_q = data_reg;

endmodule

// ===== rtl/rlq_queue.sv =====
// One FIFO built as a row of rlq_cell with the oldest entry always in cell 0,
// plus its fill count. Uses rlq_pkg and rlq_cell.
module rlq_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  rlq_pkg::q_ctrl_t  ctrl,
    input  rlq_pkg::entry_t   push_entry,
    output rlq_pkg::entry_t   head,
    output rlq_pkg::q_stat_t  stat
);

    logic [rlq_pkg::CNT_BITS-1:0] count_reg;
    logic [rlq_pkg::CNT_BITS-1:0] count_next;
    logic                         full;
    logic                         empty;
    rlq_pkg::entry_t              cell_data [rlq_pkg::QUEUE_DEPTH];

    assign full  = (count_reg == rlq_pkg::CNT_BITS'(rlq_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);

    always_comb begin
        count_next = count_reg;
        if (ctrl.flush) begin
            count_next = '0;
        end else if (ctrl.push && !full) begin
            count_next = count_reg + 1'b1;
        end else if (ctrl.pop && !empty) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // A push fills the first free cell; a pop moves every cell one place towards cell 0.
    for (genvar i = 0; i < rlq_pkg::QUEUE_DEPTH; i++) begin : g_cell
        rlq_pkg::entry_t upper;
        if (i == rlq_pkg::QUEUE_DEPTH - 1) begin : g_last
            assign upper = '0;
        end else begin : g_mid
            assign upper = cell_data[i+1];
        end
        rlq_cell u_cell (
            .aclk       (aclk),
            .load_en    (ctrl.push && !full && (count_reg == rlq_pkg::CNT_BITS'(i))),
            .shift_en   (ctrl.pop && !empty),
            .load_data  (push_entry),
            .shift_data (upper),
            .data_q     (cell_data[i])
        );
    end

    assign head              = cell_data[0];
    assign stat.full         = full;
    assign stat.empty        = empty;
    assign stat.pending_next = (count_next != '0);

endmodule

// ===== rtl/retransmit_level_queues.sv =====
// Retransmission queues per encryption level: top level with the stream ports,
// the operation decoder and the result register. Uses rlq_pkg and rlq_queue.
//
// Usage: each input transaction carries one operation in s_tuser (add to the
// initial, handshake or application level, get from a level, or drop a level)
// and its operands in s_tdata. Every accepted transaction gives exactly one
// result transaction on the m_ side: a status, whether a frame was dequeued,
// its handle, and whether initial or handshake frames are still pending.
// Each FIFO is a row of cells with its oldest entry always in the first cell,
// so a get compares only that cell's size against the budget.
// The result is registered: m_tvalid rises in the cycle after acceptance. One
// transaction is taken per cycle for as long as m_tready is high; the decode
// over the head cells and the counts of the five queues is combinational.
// The result register sits between the two sides: while it holds a result
// that the receiver stalls, s_tready is low and the queues do not change.
// Reset empties all five queues and clears m_tvalid; stored entries are not
// cleared, as nothing reads a cell beyond a queue's count.
module retransmit_level_queues (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] frame_handle, [23:16] frame_type, [39:24] frame_size,
    // [55:40] size_budget, [57:56] drop_level, [63:58] zero
    input  logic [63:0] s_tdata,
    // [2:0] func
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] frame_out, [16] has_initial, [17] has_handshake, [23:18] zero
    output logic [23:0] m_tdata,
    // [1:0] status, [2] frame_valid
    output logic [2:0]  m_tuser
);

    logic                             accept;
    rlq_pkg::func_t                   func;
    logic [15:0]                      frame_handle;
    logic [7:0]                       frame_type;
    logic [15:0]                      frame_size;
    logic [15:0]                      size_budget;
    logic [1:0]                       drop_level;

    rlq_pkg::q_ctrl_t                 q_ctrl [rlq_pkg::NUM_Q];
    rlq_pkg::entry_t                  q_head [rlq_pkg::NUM_Q];
    rlq_pkg::q_stat_t                 q_stat [rlq_pkg::NUM_Q];
    logic [rlq_pkg::NUM_Q-1:0]        fits;
    rlq_pkg::entry_t                  push_entry;

    rlq_pkg::status_t                 status;
    logic                             frame_valid;
    logic [15:0]                      frame_out;
    logic                             add_en;
    logic [rlq_pkg::QSEL_BITS-1:0]    add_q;

    logic                             m_tvalid_reg;
    logic                             m_tvalid_next;
    logic [23:0]                      m_tdata_reg;
    logic [2:0]                       m_tuser_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign func         = rlq_pkg::func_t'(s_tuser);
    assign frame_handle = s_tdata[15:0];
    assign frame_type   = s_tdata[23:16];
    assign frame_size   = s_tdata[39:24];
    assign size_budget  = s_tdata[55:40];
    assign drop_level   = s_tdata[57:56];

    assign push_entry.handle = frame_handle[rlq_pkg::HANDLE_BITS-1:0];
    assign push_entry.size   = frame_size[rlq_pkg::SIZE_BITS-1:0];

    for (genvar q = 0; q < rlq_pkg::NUM_Q; q++) begin : g_q
        assign fits[q] = !q_stat[q].empty && (q_head[q].size <= size_budget);
        rlq_queue u_queue (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (q_ctrl[q]),
            .push_entry (push_entry),
            .head       (q_head[q]),
            .stat       (q_stat[q])
        );
    end

    always_comb begin
        for (int q = 0; q < rlq_pkg::NUM_Q; q++) begin
            q_ctrl[q] = '0;
        end
        status      = rlq_pkg::ST_OK;
        frame_valid = 1'b0;
        frame_out   = '0;
        add_en      = 1'b0;
        add_q       = rlq_pkg::Q_APP;
        if (accept) begin
            case (func)
                rlq_pkg::FUNC_ADD_INIT: begin
                    add_en = 1'b1;
                    add_q  = (frame_type == rlq_pkg::CRYPTO_TYPE) ?
                             rlq_pkg::Q_INIT_CRYPTO : rlq_pkg::Q_INIT_PLAIN;
                end
                rlq_pkg::FUNC_ADD_HS: begin
                    add_en = 1'b1;
                    add_q  = (frame_type == rlq_pkg::CRYPTO_TYPE) ?
                             rlq_pkg::Q_HS_CRYPTO : rlq_pkg::Q_HS_PLAIN;
                end
                rlq_pkg::FUNC_ADD_APP: begin
                    add_en = 1'b1;
                    add_q  = rlq_pkg::Q_APP;
                end
                rlq_pkg::FUNC_GET_INIT: begin
                    // Crypto frames take precedence over plain frames of the same level.
                    if (fits[rlq_pkg::Q_INIT_CRYPTO]) begin
                        q_ctrl[rlq_pkg::Q_INIT_CRYPTO].pop = 1'b1;
                        frame_valid = 1'b1;
                        frame_out   = 16'(q_head[rlq_pkg::Q_INIT_CRYPTO].handle);
                    end else if (fits[rlq_pkg::Q_INIT_PLAIN]) begin
                        q_ctrl[rlq_pkg::Q_INIT_PLAIN].pop = 1'b1;
                        frame_valid = 1'b1;
                        frame_out   = 16'(q_head[rlq_pkg::Q_INIT_PLAIN].handle);
                    end
                end
                rlq_pkg::FUNC_GET_HS: begin
                    if (fits[rlq_pkg::Q_HS_CRYPTO]) begin
                        q_ctrl[rlq_pkg::Q_HS_CRYPTO].pop = 1'b1;
                        frame_valid = 1'b1;
                        frame_out   = 16'(q_head[rlq_pkg::Q_HS_CRYPTO].handle);
                    end else if (fits[rlq_pkg::Q_HS_PLAIN]) begin
                        q_ctrl[rlq_pkg::Q_HS_PLAIN].pop = 1'b1;
                        frame_valid = 1'b1;
                        frame_out   = 16'(q_head[rlq_pkg::Q_HS_PLAIN].handle);
                    end
                end
                rlq_pkg::FUNC_GET_APP: begin
                    if (fits[rlq_pkg::Q_APP]) begin
                        q_ctrl[rlq_pkg::Q_APP].pop = 1'b1;
                        frame_valid = 1'b1;
                        frame_out   = 16'(q_head[rlq_pkg::Q_APP].handle);
                    end
                end
                rlq_pkg::FUNC_DROP: begin
                    case (drop_level)
                        rlq_pkg::LVL_INIT: begin
                            q_ctrl[rlq_pkg::Q_INIT_PLAIN].flush  = 1'b1;
                            q_ctrl[rlq_pkg::Q_INIT_CRYPTO].flush = 1'b1;
                        end
                        rlq_pkg::LVL_HS: begin
                            q_ctrl[rlq_pkg::Q_HS_PLAIN].flush  = 1'b1;
                            q_ctrl[rlq_pkg::Q_HS_CRYPTO].flush = 1'b1;
                        end
                        default: begin
                            status = rlq_pkg::ST_BAD_LEVEL;
                        end
                    endcase
                end
                default: begin
                end
            endcase
            if (add_en) begin
                if (q_stat[add_q].full) begin
                    status = rlq_pkg::ST_FULL;
                end else begin
                    q_ctrl[add_q].push = 1'b1;
                end
            end
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {6'd0,
                            q_stat[rlq_pkg::Q_HS_PLAIN].pending_next ||
                            q_stat[rlq_pkg::Q_HS_CRYPTO].pending_next,
                            q_stat[rlq_pkg::Q_INIT_PLAIN].pending_next ||
                            q_stat[rlq_pkg::Q_INIT_CRYPTO].pending_next,
                            frame_out};
            m_tuser_reg <= {frame_valid, status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // A dequeued frame always comes with an ok status.
    a_valid_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tuser_reg[2] |-> m_tuser_reg[1:0] == rlq_pkg::ST_OK)
        else $error("frame returned with a non-ok status");

    // A valid drop of the initial level leaves nothing pending there.
    a_drop_init: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && func == rlq_pkg::FUNC_DROP && drop_level == rlq_pkg::LVL_INIT
        |=> !m_tdata_reg[16])
        else $error("initial level still pending after drop");

    a_drop_hs: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && func == rlq_pkg::FUNC_DROP && drop_level == rlq_pkg::LVL_HS
        |=> !m_tdata_reg[17])
        else $error("handshake level still pending after drop");

    // The input side stalls only behind a held result.
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid_reg && !m_tready)
        else $error("input stalled without a held result");

endmodule
